// ----- rtl/cir_pkg.sv -----
package cir_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int POS_FRAC_BITS  = 16;
    localparam int SEGMENT_STRIDE = 3;
    localparam int MAX_RESULTS    = 64;
    localparam int STEP_BITS      = 20;
    localparam int LIMIT_BITS     = 32;
    localparam int INDEX_BITS     = 32;
    localparam int POS_BITS       = INDEX_BITS + POS_FRAC_BITS + 1;
    localparam int N_BITS         = $clog2(MAX_RESULTS + 1);
    localparam int TW             = SAMPLE_BITS + 12;
    localparam int V_BITS         = TW - 1;
    localparam int DIV_SHIFT      = TW;
    localparam int DIV_OFS        = 3 * (2 ** (TW - 4));
    localparam int DIV_BIAS       = 2 ** (TW - 4);
    localparam longint DIV_RECIP  = ((longint'(1) << DIV_SHIFT) + 2) / 3;
    localparam int MIN_STEP       = SEGMENT_STRIDE << (POS_FRAC_BITS - 6);
    localparam int SAT_MAX        = (2 ** (SAMPLE_BITS - 1)) - 1;
    localparam int SAT_MIN        = -(2 ** (SAMPLE_BITS - 1));
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;

    localparam logic REG_POSITION_STEP = 1'b0;
    localparam logic REG_OUTPUT_LIMIT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SAT,
        ST_EMIT,
        ST_WRAP
    } cir_state_t;

    typedef struct packed {
        logic       in_ready;
        logic       take;
        logic       check;
        logic       load;
        logic       mul;
        logic       acc;
        logic [1:0] stage;
        logic       div;
        logic       sat;
        logic       emit;
        logic       wrap;
    } cir_cmd_t;

    typedef struct packed {
        logic run;
        logic frac_zero;
        logic cont;
        logic out_free;
    } cir_stat_t;

endpackage

// ----- rtl/cir_if.sv -----
interface cir_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cir_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                   final_sample;

    modport source (output valid, output sample_in, output final_sample, input ready);
    modport sink (input valid, input sample_in, input final_sample, output ready);
endinterface

interface cir_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cir_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                   run_end;
    logic                                   stream_done;

    modport source (output valid, output sample_out, output run_end, output stream_done,
                    input ready);
    modport sink (input valid, input sample_out, input run_end, input stream_done,
                  output ready);
endinterface

// ----- rtl/cir_ctrl.sv -----
module cir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cir_pkg::cir_stat_t  stat,
    output cir_pkg::cir_cmd_t   cmd
);
    import cir_pkg::*;

    cir_state_t state_reg, state_next;
    logic [1:0] stage_reg, stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.run ? ST_LOAD : ST_WRAP;
            end
            ST_LOAD:
            begin
                stage_next = 2'd0;
                state_next = stat.frac_zero ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (stage_reg == 2'd2)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.cont ? ST_LOAD : ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.stage    = stage_reg;
        cmd.in_ready = (state_reg == ST_IDLE);
        cmd.take     = (state_reg == ST_IDLE) && in_valid;
        cmd.check    = (state_reg == ST_CHECK);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.acc      = (state_reg == ST_ACC);
        cmd.div      = (state_reg == ST_DIV);
        cmd.sat      = (state_reg == ST_SAT);
        cmd.emit     = (state_reg == ST_EMIT) && stat.out_free;
        cmd.wrap     = (state_reg == ST_WRAP);
    end

endmodule

// ----- rtl/cir_dp.sv -----
module cir_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cir_pkg::cir_cmd_t                       cmd,
    output cir_pkg::cir_stat_t                      stat,
    input  logic signed [cir_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic                                    final_sample,
    input  logic [cir_pkg::STEP_BITS-1:0]           position_step,
    input  logic [cir_pkg::LIMIT_BITS-1:0]          output_limit,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic signed [cir_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                    run_end,
    output logic                                    stream_done
);
    import cir_pkg::*;

    localparam logic [V_BITS-1:0] RECIP = V_BITS'(DIV_RECIP);

    logic signed [SAMPLE_BITS-1:0]    seg_reg [4];
    logic [INDEX_BITS-1:0]            index_reg;
    logic [INDEX_BITS-1:0]            base_reg;
    logic [1:0]                       slot_reg;
    logic [POS_BITS-1:0]              accum_reg;
    logic [LIMIT_BITS-1:0]            count_reg;
    logic                             finished_reg;
    logic                             fin_reg;
    logic [N_BITS-1:0]                n_reg;
    logic [1:0]                       rel_reg;
    logic [POS_FRAC_BITS-1:0]         xf_reg;
    logic signed [TW-1:0]             w_reg;
    logic signed [TW+POS_FRAC_BITS:0] prod_reg;
    logic [2*V_BITS-1:0]              divp_reg;
    logic signed [SAMPLE_BITS-1:0]    res_reg;
    logic                             out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]    sample_out_reg;
    logic                             run_end_reg;
    logic                             stream_done_reg;

    logic [STEP_BITS-1:0]             step_eff;
    logic [POS_BITS-1:0]              lastpos;
    logic                             boundary;
    logic                             pos_ok;
    logic                             below_limit;
    logic                             done;
    logic [INDEX_BITS:0]              pint;
    logic [INDEX_BITS:0]              rel_diff;
    logic [1:0]                       rel;
    logic signed [TW-1:0]             s0, s1, s2, s3;
    logic signed [TW-1:0]             d1, d2, d3;
    logic signed [3:0]                xi_s;
    logic signed [TW-1:0]             addend;
    logic signed [TW-1:0]             t_acc;
    logic signed [TW-1:0]             u_val;
    logic signed [TW-1:0]             h_val;
    logic [V_BITS-1:0]                v_val;
    logic signed [TW-1:0]             r_val;
    logic signed [SAMPLE_BITS-1:0]    sat_val;

    always_comb
    begin
        step_eff    = (position_step < STEP_BITS'(MIN_STEP)) ? STEP_BITS'(MIN_STEP)
                                                             : position_step;
        lastpos     = {1'b0, index_reg, {POS_FRAC_BITS{1'b0}}};
        boundary    = (index_reg == '0) || (slot_reg == 2'd3);
        pos_ok      = (accum_reg <= lastpos);
        below_limit = (count_reg < output_limit);
        done        = fin_reg || !below_limit;

        pint     = accum_reg[POS_BITS-1:POS_FRAC_BITS];
        rel_diff = pint - {1'b0, base_reg};
        if (pint < {1'b0, base_reg})
        begin
            rel = 2'd0;
        end
        else if (rel_diff > (INDEX_BITS+1)'(3))
        begin
            rel = 2'd3;
        end
        else
        begin
            rel = rel_diff[1:0];
        end

        s0 = TW'(seg_reg[0]);
        s1 = TW'(seg_reg[1]);
        s2 = TW'(seg_reg[2]);
        s3 = TW'(seg_reg[3]);
        d1 = s1 - s0;
        d2 = s2 - (s1 <<< 1) + s0;
        d3 = s3 - (s2 <<< 1) - s2 + (s1 <<< 1) + s1 - s0;

        xi_s = $signed({2'b00, rel_reg}) - $signed(4'(2 - int'(cmd.stage)));
        case (cmd.stage)
            2'd0:    addend = (d2 <<< 1) + d2;
            2'd1:    addend = (d1 <<< 2) + (d1 <<< 1);
            default: addend = (s0 <<< 2) + (s0 <<< 1);
        endcase
        t_acc = TW'(w_reg * xi_s) + TW'(prod_reg >>> POS_FRAC_BITS) + addend;

        u_val = w_reg + TW'(3);
        h_val = u_val >>> 1;
        v_val = V_BITS'(h_val + DIV_OFS);

        r_val = $signed(TW'(divp_reg[2*V_BITS-1:DIV_SHIFT])) - TW'(DIV_BIAS);
        if (r_val > SAT_MAX)
        begin
            sat_val = SAMPLE_BITS'(SAT_MAX);
        end
        else if (r_val < SAT_MIN)
        begin
            sat_val = SAMPLE_BITS'(SAT_MIN);
        end
        else
        begin
            sat_val = r_val[SAMPLE_BITS-1:0];
        end

        stat.run       = !finished_reg && (fin_reg || boundary) && below_limit && pos_ok;
        stat.frac_zero = (accum_reg[POS_FRAC_BITS-1:0] == '0);
        stat.cont      = (n_reg < N_BITS'(MAX_RESULTS)) && below_limit && pos_ok;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                seg_reg[i] <= '0;
            end
            index_reg     <= '0;
            base_reg      <= '0;
            slot_reg      <= 2'd0;
            accum_reg     <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                fin_reg <= final_sample;
                if (!finished_reg)
                begin
                    seg_reg[slot_reg] <= sample_in;
                end
            end
            if (cmd.check)
            begin
                n_reg <= '0;
            end
            if (cmd.load)
            begin
                accum_reg <= accum_reg + POS_BITS'(step_eff);
                count_reg <= count_reg + 1'b1;
                n_reg     <= n_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.wrap && !finished_reg)
            begin
                finished_reg <= done;
                if ((index_reg != '0) && boundary)
                begin
                    seg_reg[0] <= seg_reg[3];
                    seg_reg[1] <= '0;
                    seg_reg[2] <= '0;
                    seg_reg[3] <= '0;
                end
                if (index_reg != '1)
                begin
                    index_reg <= index_reg + 1'b1;
                    if (slot_reg == 2'd3)
                    begin
                        slot_reg <= 2'd1;
                        base_reg <= base_reg + INDEX_BITS'(SEGMENT_STRIDE);
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rel_reg <= rel;
            xf_reg  <= accum_reg[POS_FRAC_BITS-1:0];
            w_reg   <= d3;
            res_reg <= seg_reg[rel];
        end
        if (cmd.mul)
        begin
            prod_reg <= w_reg * $signed({1'b0, xf_reg});
        end
        if (cmd.acc)
        begin
            w_reg <= t_acc;
        end
        if (cmd.div)
        begin
            divp_reg <= v_val * RECIP;
        end
        if (cmd.sat)
        begin
            res_reg <= sat_val;
        end
        if (cmd.emit)
        begin
            sample_out_reg  <= res_reg;
            run_end_reg     <= !stat.cont;
            stream_done_reg <= !stat.cont && done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign run_end     = run_end_reg;
    assign stream_done = stream_done_reg;

endmodule

// ----- rtl/cubic_interp_resampler.sv -----
// Piecewise cubic Lagrange resampler. Each input item passes through the idle,
// check and wrap bookkeeping states, and each result it causes passes through
// load and emit when the output position falls on a whole input sample, and
// otherwise also through Horner mul/acc steps that reuse the fractional-product
// multiplier, a reciprocal multiply for the final division by six and a
// saturation step. A boundary sample can cause up to 64 results; the output
// register lets the next item be taken while the last result still waits for its consumer.
module cubic_interp_resampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cir_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [cir_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [cir_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    cir_in_if.sink                               in_ch,
    cir_out_if.source                            out_ch
);
    import cir_pkg::*;

    logic [STEP_BITS-1:0]  step_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    cir_cmd_t              cmd;
    cir_stat_t             stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_BITS'(1 << POS_FRAC_BITS);
            limit_reg <= '1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_POSITION_STEP: step_reg  <= pwdata[STEP_BITS-1:0];
                REG_OUTPUT_LIMIT:  limit_reg <= pwdata[LIMIT_BITS-1:0];
                default:           limit_reg <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POSITION_STEP: prdata = CFG_DATA_BITS'(step_reg);
            REG_OUTPUT_LIMIT:  prdata = CFG_DATA_BITS'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign in_ch.ready = cmd.in_ready;

    cir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    cir_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample_in     (in_ch.sample_in),
        .final_sample  (in_ch.final_sample),
        .position_step (step_reg),
        .output_limit  (limit_reg),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .sample_out    (out_ch.sample_out),
        .run_end       (out_ch.run_end),
        .stream_done   (out_ch.stream_done)
    );

endmodule
